// ===== hw/rtl/qat_pkg.sv =====
package qat_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [63:0] LIMIT_MAX = 64'h0000_0000_ffff_ffff;
    localparam logic [63:0] SPACE_MAX = 64'h0000_03ff_ffff_fc00;

    typedef enum logic [2:0] {
        K_SET    = 3'd0,
        K_CHARGE = 3'd1,
        K_REFUND = 3'd2,
        K_QUERY  = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNSUPPORTED = 3'd1,
        ST_OVERFLOW    = 3'd2,
        ST_FULL        = 3'd3,
        ST_LIMIT       = 3'd4,
        ST_NOT_FOUND   = 3'd5,
        ST_UNDERFLOW   = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] block_lim;
        logic [31:0] inode_lim;
        logic [41:0] space;
        logic [31:0] inode_cnt;
        logic        dirty;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic        blk_given;
        logic        ino_given;
        logic [31:0] block_hard;
        logic [31:0] inode_hard;
        logic [63:0] bytes;
        logic [63:0] inodes;
        logic        enforce;
    } t_req;

endpackage

// ===== hw/rtl/quota_accounting_table.sv =====
// quota table kept sorted by owner id, one request at a time
// input channel: i_in_valid / o_in_stall carry one request (kind, owner id,
//   limits, amounts); a request is taken when valid is high and stall low
// output channel: o_out_valid / i_out_stall carry one result per request:
//   status, the located entry after any update, and the entry count
// sequence: a binary search over the filled entries, one memory read per
//   step, then a probe and update of the located entry; when set inserts
//   a new id, each entry above the slot is read and written one place up
//   before the new entry is written; clear, rejected sets and unknown kinds
//   skip the search
// throughput: one request in flight; the entry memory's single read port
//   and the search loop set the rate
// the output register holds a finished result while the next request is
//   already taken; a stalled result holds, and the block waits at the end
//   of the next request until the result register is free
// reset clears the fill count and the control state; the entry memory has
//   no reset, entries beyond the fill count are never read
module quota_accounting_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_owner_id,
    input  logic        i_block_limit_given,
    input  logic        i_inode_limit_given,
    input  logic        i_other_fields_given,
    input  logic [63:0] i_new_block_hard,
    input  logic [63:0] i_new_block_soft,
    input  logic [63:0] i_new_inode_hard,
    input  logic [63:0] i_new_inode_soft,
    input  logic [63:0] i_byte_amount,
    input  logic [63:0] i_inode_amount,
    input  logic        i_enforce_limits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_block_hard_out,
    output logic [31:0] o_inode_hard_out,
    output logic [41:0] o_space_used,
    output logic [31:0] o_inodes_used,
    output logic        o_entry_dirty,
    output logic [6:0]  o_entries_in_use
);
    import qat_pkg::*;

    // entry memory, one read and one write port, registered read data
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W-1:0] mem_ra;
    t_entry           mem_wd;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    t_status r_res_status, n_res_status;
    t_entry  r_res_entry, n_res_entry;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_entry  r_out_entry, n_out_entry;
    logic [6:0] r_out_fill, n_out_fill;

    logic accept;
    logic out_free;
    logic search_more;
    logic hit;
    logic full;
    logic is_set;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] ptr_dec;
    t_status set_chk;
    t_req    in_req;
    t_entry  fresh;
    t_entry  upd_in;
    t_entry  upd_entry;
    t_status upd_status;
    logic    upd_write;

    // field checks of a set request, in priority order
    function automatic t_status check_set(input logic other, input logic blk,
                                          input logic ino, input logic [63:0] bs,
                                          input logic [63:0] is,
                                          input logic [63:0] bh,
                                          input logic [63:0] ih);
        t_status st;
        st = ST_OK;
        if (other) begin
            st = ST_UNSUPPORTED;
        end else if ((blk && bs != 64'd0) || (ino && is != 64'd0)) begin
            st = ST_UNSUPPORTED;
        end else if ((blk && bh > LIMIT_MAX) || (ino && ih > LIMIT_MAX)) begin
            st = ST_OVERFLOW;
        end
        return st;
    endfunction

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign search_more = r_lo < r_hi;
    assign hit         = (r_rd_data.key == r_req.id);
    assign full        = (r_fill == CNT_W'(TABLE_DEPTH));
    assign is_set      = (t_kind'(r_req.kind) == K_SET);
    assign mid         = r_lo + ((r_hi - r_lo) >> 1);
    assign ptr_dec     = r_ptr - 1'b1;

    assign set_chk = check_set(i_other_fields_given, i_block_limit_given,
                               i_inode_limit_given, i_new_block_soft, i_new_inode_soft,
                               i_new_block_hard, i_new_inode_hard);

    always_comb begin
        in_req            = '0;
        in_req.kind       = i_kind;
        in_req.id         = i_owner_id;
        in_req.blk_given  = i_block_limit_given;
        in_req.ino_given  = i_inode_limit_given;
        in_req.block_hard = i_new_block_hard[31:0];
        in_req.inode_hard = i_new_inode_hard[31:0];
        in_req.bytes      = i_byte_amount;
        in_req.inodes     = i_inode_amount;
        in_req.enforce    = i_enforce_limits;
    end

    // a freshly inserted entry starts all zero with its key
    always_comb begin
        fresh     = '0;
        fresh.key = r_req.id;
    end

    assign upd_in = (r_state == S_INSERT) ? fresh : r_rd_data;

    qat_update u_update (
        .i_req    (r_req),
        .i_entry  (upd_in),
        .o_entry  (upd_entry),
        .o_status (upd_status),
        .o_write  (upd_write)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        K_SET:    n_state = (set_chk == ST_OK) ? S_SEARCH : S_DONE;
                        K_CHARGE: n_state = S_SEARCH;
                        K_REFUND: n_state = S_SEARCH;
                        K_QUERY:  n_state = S_SEARCH;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (search_more) begin
                    n_state = S_COMPARE;
                end else if (r_lo < r_fill) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = (is_set && !full) ? S_SHIFT_RD : S_DONE;
                end
            end
            S_COMPARE: n_state = S_SEARCH;
            S_CHECK: begin
                if (hit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (is_set && !full) ? S_SHIFT_RD : S_DONE;
                end
            end
            S_SHIFT_RD: n_state = (r_ptr > r_lo) ? S_SHIFT_WR : S_INSERT;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_INSERT:   n_state = S_DONE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_req        = r_req;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_ptr        = r_ptr;
        n_fill       = r_fill;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_fill   = r_out_fill;
        mem_we = 1'b0;
        mem_wa = r_lo[IDX_W-1:0];
        mem_wd = upd_entry;
        mem_ra = r_lo[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req       = in_req;
                    n_lo        = '0;
                    n_hi        = r_fill;
                    n_ptr       = r_fill;
                    n_res_entry = '0;
                    unique case (t_kind'(i_kind))
                        K_SET:    n_res_status = set_chk;
                        K_CHARGE: n_res_status = ST_OK;
                        K_REFUND: n_res_status = ST_OK;
                        K_QUERY:  n_res_status = ST_OK;
                        K_CLEAR: begin
                            n_res_status = ST_OK;
                            n_fill       = '0;
                        end
                        default:  n_res_status = ST_UNSUPPORTED;
                    endcase
                end
            end
            S_SEARCH: begin
                n_ptr = r_fill;
                if (search_more) begin
                    mem_ra = mid[IDX_W-1:0];
                    n_mid  = mid;
                end else if (r_lo >= r_fill) begin
                    // id beyond every stored key
                    if (!is_set) begin
                        n_res_status = ST_NOT_FOUND;
                    end else if (full) begin
                        n_res_status = ST_FULL;
                    end
                end
            end
            S_COMPARE: begin
                if (r_rd_data.key < r_req.id) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
            end
            S_CHECK: begin
                if (hit) begin
                    mem_we       = upd_write;
                    n_res_status = upd_status;
                    n_res_entry  = upd_entry;
                end else if (!is_set) begin
                    n_res_status = ST_NOT_FOUND;
                end else if (full) begin
                    n_res_status = ST_FULL;
                end
            end
            S_SHIFT_RD: begin
                mem_ra = ptr_dec[IDX_W-1:0];
            end
            S_SHIFT_WR: begin
                // move one entry up to open the insert slot
                mem_we = 1'b1;
                mem_wa = r_ptr[IDX_W-1:0];
                mem_wd = r_rd_data;
                n_ptr  = ptr_dec;
            end
            S_INSERT: begin
                mem_we       = 1'b1;
                n_fill       = r_fill + 1'b1;
                n_res_status = upd_status;
                n_res_entry  = upd_entry;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_fill   = 7'(r_fill);
                end
            end
            default: begin
                n_req = r_req;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_ptr        <= n_ptr;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_fill   <= n_out_fill;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_block_hard_out = r_out_entry.block_lim;
    assign o_inode_hard_out = r_out_entry.inode_lim;
    assign o_space_used     = r_out_entry.space;
    assign o_inodes_used    = r_out_entry.inode_cnt;
    assign o_entry_dirty    = r_out_entry.dirty;
    assign o_entries_in_use = r_out_fill;

endmodule

// ===== hw/rtl/qat_update.sv =====
module qat_update (
    input  qat_pkg::t_req    i_req,
    input  qat_pkg::t_entry  i_entry,
    output qat_pkg::t_entry  o_entry,
    output qat_pkg::t_status o_status,
    output logic             o_write
);
    import qat_pkg::*;

    logic [63:0] sp64;
    logic [63:0] ic64;
    logic [63:0] sp_sum;
    logic [63:0] ic_sum;
    logic [63:0] sp_lim;
    logic        ovf;
    logic        over_lim;

    assign sp64   = {22'd0, i_entry.space};
    assign ic64   = {32'd0, i_entry.inode_cnt};
    assign sp_sum = sp64 + i_req.bytes;
    assign ic_sum = ic64 + i_req.inodes;
    assign sp_lim = {22'd0, i_entry.block_lim, 10'd0};
    assign ovf    = (i_req.bytes > (SPACE_MAX - sp64)) || (i_req.inodes > (LIMIT_MAX - ic64));
    assign over_lim = i_req.enforce &&
        (((i_req.bytes != 64'd0) && (i_entry.block_lim != 32'd0) && (sp_sum > sp_lim)) ||
         ((i_req.inodes != 64'd0) && (i_entry.inode_lim != 32'd0) &&
          (ic_sum > {32'd0, i_entry.inode_lim})));

    always_comb begin
        o_entry  = i_entry;
        o_status = ST_OK;
        o_write  = 1'b0;
        unique case (t_kind'(i_req.kind))
            K_SET: begin
                if (i_req.blk_given) begin
                    o_entry.block_lim = i_req.block_hard;
                end
                if (i_req.ino_given) begin
                    o_entry.inode_lim = i_req.inode_hard;
                end
                o_entry.dirty = 1'b1;
                o_write = 1'b1;
            end
            K_CHARGE: begin
                if (ovf) begin
                    o_status = ST_OVERFLOW;
                end else if (over_lim) begin
                    o_status = ST_LIMIT;
                end else begin
                    o_entry.space     = sp_sum[41:0];
                    o_entry.inode_cnt = ic_sum[31:0];
                    o_entry.dirty     = 1'b1;
                    o_write = 1'b1;
                end
            end
            K_REFUND: begin
                if ((i_req.bytes > sp64) || (i_req.inodes > ic64)) begin
                    o_status = ST_UNDERFLOW;
                end else begin
                    o_entry.space     = i_entry.space - i_req.bytes[41:0];
                    o_entry.inode_cnt = i_entry.inode_cnt - i_req.inodes[31:0];
                    o_entry.dirty     = 1'b1;
                    o_write = 1'b1;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule
